[rtl/kbrs_pkg.sv]
// Shared types and constants for the keyboard register slave with key FIFO.
package kbrs_pkg;

	// Item kinds carried in the input tuser
	typedef enum logic [1:0] {
		OP_PUSH_CODE  = 2'd0,
		OP_PUSH_INDEX = 2'd1,
		OP_BUS_WRITE  = 2'd2,
		OP_BUS_READ   = 2'd3
	} op_t;

	// Sequencer states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_POP  = 1'b1
	} state_t;

	// Register map and command bytes
	localparam logic [7:0] REG_VERSION  = 8'hF1;
	localparam logic [7:0] REG_TEST     = 8'hF0;
	localparam logic [7:0] TEST_ENTER   = 8'h01;
	localparam logic [7:0] FW_VER_RESET = 8'h01;
	localparam logic [7:0] SEL_RESET    = 8'h00;

	// One result word before packing
	typedef struct packed {
		logic       test_mode_request;
		logic       push_accepted;
		logic       key_popped;
		logic [7:0] read_data;
	} result_t;

endpackage

[rtl/keyboard_register_slave_with_key_fifo.sv]
// Keyboard register slave: key FIFO in a synchronous RAM, register select and result stage.
// Each input word is one operation: push a key code, push a key index, a bus write that selects
// a register (and may request test mode), or a bus read. Pushes, bus writes and version reads
// load the result stage directly; with the result side ready, a new word is taken every cycle.
// A bus read that pops a key passes through the ST_POP wait state, where no new word is taken:
// the key RAM read port is registered, so the oldest key loads the result stage from there. The
// FIFO has QUEUE_DEPTH slots of which one always stays free, so it holds QUEUE_DEPTH - 1 keys;
// a push into a full FIFO, and a key-code push of zero, are refused and flagged as such. The
// key RAM needs no clearing after reset: only slots already written are ever read. Exactly
// one result word leaves for every input word, through a result register that lets the next
// input word in while the last result is being taken. The version byte is written through
// cfg_wr_en / cfg_wr_data and resets to 1; write it only while the block is idle.
module keyboard_register_slave_with_key_fifo #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: version byte
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] push_value, [15:8] reg_addr, [23:16] write_value
	input  logic [2:0]  s_tuser,   // [1:0] operation, [2] write_has_value
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [7:0] read_data, [8] key_popped, [9] push_accepted,
	                               // [10] test_mode_request, [15:11] zero
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

	// input fields
	kbrs_pkg::op_t op;
	logic [7:0]    push_value;
	logic [7:0]    reg_addr;
	logic [7:0]    write_value;
	logic          write_has_value;

	assign op              = kbrs_pkg::op_t'(s_tuser[1:0]);
	assign write_has_value = s_tuser[2];
	assign push_value      = s_tdata[7:0];
	assign reg_addr        = s_tdata[15:8];
	assign write_value     = s_tdata[23:16];

	// control state
	kbrs_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [7:0]       sel_q;
	logic [7:0]       fw_ver_q;

	// result stage payload
	kbrs_pkg::result_t res_q;

	// key RAM
	logic [7:0] key_mem [QUEUE_DEPTH];
	logic [7:0] key_rdata_s1;

	// decode
	logic             in_acc;
	logic             out_free;
	logic [IDX_W-1:0] wr_nxt;
	logic [IDX_W-1:0] rd_nxt;
	logic             fifo_full;
	logic             fifo_empty;
	logic             push_ok;
	logic             pop_go;
	logic             ver_read;
	kbrs_pkg::result_t res_d;

	assign wr_nxt     = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
	assign rd_nxt     = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
	assign fifo_full  = (wr_nxt == rd_idx_q);
	assign fifo_empty = (wr_idx_q == rd_idx_q);

	// result stage can take a word this cycle if empty or being drained
	assign out_free = !out_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kbrs_pkg::ST_IDLE: begin
				if (in_acc && pop_go) state_d = kbrs_pkg::ST_POP;
			end
			kbrs_pkg::ST_POP: begin
				state_d = kbrs_pkg::ST_IDLE;
			end
			default: state_d = kbrs_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		unique case (state_q)
			kbrs_pkg::ST_IDLE: s_tready = out_free;
			kbrs_pkg::ST_POP:  s_tready = 1'b0;
			default:           s_tready = 1'b0;
		endcase
	end

	// operation decode; result for everything but a key pop
	always_comb begin
		push_ok  = 1'b0;
		pop_go   = 1'b0;
		ver_read = 1'b0;
		res_d    = '0;
		unique case (op)
			kbrs_pkg::OP_PUSH_CODE: begin
				push_ok = (push_value != 8'd0) && !fifo_full;
				res_d.push_accepted = push_ok;
			end
			kbrs_pkg::OP_PUSH_INDEX: begin
				push_ok = !fifo_full;
				res_d.push_accepted = push_ok;
			end
			kbrs_pkg::OP_BUS_WRITE: begin
				res_d.test_mode_request = write_has_value
					&& (reg_addr == kbrs_pkg::REG_TEST)
					&& (write_value == kbrs_pkg::TEST_ENTER);
			end
			kbrs_pkg::OP_BUS_READ: begin
				priority if (sel_q == kbrs_pkg::REG_VERSION) begin
					ver_read = 1'b1;
					res_d.read_data = fw_ver_q;
				end else if (!fifo_empty) begin
					pop_go = 1'b1;
				end else begin
					res_d.read_data = 8'd0;
				end
			end
			default: res_d = '0;
		endcase
	end

	// key RAM: one write port, one registered read port. A pop reads the
	// oldest slot, which never equals the write slot while the FIFO is non-empty.
	always_ff @(posedge clk) begin
		if (in_acc && push_ok) key_mem[wr_idx_q] <= push_value;
		if (in_acc && pop_go)  key_rdata_s1 <= key_mem[rd_idx_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kbrs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			sel_q       <= kbrs_pkg::SEL_RESET;
			fw_ver_q    <= kbrs_pkg::FW_VER_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) fw_ver_q <= cfg_wr_data;
			if (in_acc) begin
				if (push_ok) wr_idx_q <= wr_nxt;
				if (pop_go)  rd_idx_q <= rd_nxt;
				if (op == kbrs_pkg::OP_BUS_WRITE) sel_q <= reg_addr;
				if (ver_read) sel_q <= kbrs_pkg::SEL_RESET;
			end
			// a key pop loads the result stage from the ST_POP wait state
			if ((in_acc && !pop_go) || state_q == kbrs_pkg::ST_POP) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc && !pop_go) begin
			res_q <= res_d;
		end else if (state_q == kbrs_pkg::ST_POP) begin
			res_q.read_data         <= key_rdata_s1;
			res_q.key_popped        <= 1'b1;
			res_q.push_accepted     <= 1'b0;
			res_q.test_mode_request <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, res_q};

	// the pop wait cycle always finds the result stage free
	a_pop_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kbrs_pkg::ST_POP |-> !out_valid_q)
		else $error("result stage busy during key pop");

	// the read slot only moves when a pop is under way
	a_rd_moves_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q != $past(rd_idx_q) |-> state_q == kbrs_pkg::ST_POP)
		else $error("read slot moved without a pop");

	// a push never runs the write slot onto the read slot
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		wr_idx_q != $past(wr_idx_q) |-> wr_idx_q != rd_idx_q)
		else $error("key FIFO overfilled");

endmodule
